// File: rtl/core/html_entity_decoder_defines.svh
// Assertion macros shared by the checker.
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// Check on every edge, reset included.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Check outside reset only.
`define HED_ASSERT_NEXT_RUN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hed_pkg.sv
`default_nettype none
package hed_pkg;

  localparam int CAPTURE_DEPTH_DEF = 16;
  localparam int NAME_COUNT        = 252;
  localparam int NAME_IW           = $clog2(NAME_COUNT);

  localparam logic [15:0] CH_AMP   = 16'h0026;
  localparam logic [15:0] CH_SEMI  = 16'h003B;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_X     = 16'h0078;

  // output source select
  localparam logic [1:0] SEL_VAL = 2'd0;
  localparam logic [1:0] SEL_AMP = 2'd1;
  localparam logic [1:0] SEL_BUF = 2'd2;
  localparam logic [1:0] SEL_CH  = 2'd3;

  typedef struct packed {
    logic [15:0] char_in;
    logic        last_in;
  } hed_in_t;

  typedef struct packed {
    logic [15:0] char_out;
    logic        last_out;
  } hed_out_t;

  typedef struct packed {
    logic       accept;
    logic       cap_val;
    logic       append;
    logic       cnt_clr;
    logic       scan;
    logic       emit;
    logic [1:0] sel;
    logic       emit_last;
    logic       idx_inc;
  } hed_cmd_t;

  typedef struct packed {
    logic in_cap;
    logic in_amp;
    logic in_term;
    logic in_semi;
    logic in_last;
    logic full;
    logic cnt_zero;
    logic hash;
    logic num_ok;
    logic scan_hit;
    logic scan_end;
    logic idx_end;
    logic out_free;
    logic last_r;
  } hed_stat_t;

  typedef struct packed {
    logic [63:0] label;
    logic [15:0] point;
  } name_ent_t;

  function automatic logic [3:0] name_len(input logic [63:0] label);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (label[i*8 +: 8] != 8'h00) n = n + 4'd1;
    end
    return n;
  endfunction

  localparam name_ent_t NAME_ROM [NAME_COUNT] = '{
    '{"nbsp",16'd160},'{"iexcl",16'd161},'{"cent",16'd162},'{"pound",16'd163},
    '{"curren",16'd164},'{"yen",16'd165},'{"brvbar",16'd166},'{"sect",16'd167},
    '{"uml",16'd168},'{"copy",16'd169},'{"ordf",16'd170},'{"laquo",16'd171},
    '{"not",16'd172},'{"shy",16'd173},'{"reg",16'd174},'{"macr",16'd175},
    '{"deg",16'd176},'{"plusmn",16'd177},'{"sup2",16'd178},'{"sup3",16'd179},
    '{"acute",16'd180},'{"micro",16'd181},'{"para",16'd182},'{"middot",16'd183},
    '{"cedil",16'd184},'{"sup1",16'd185},'{"ordm",16'd186},'{"raquo",16'd187},
    '{"frac14",16'd188},'{"frac12",16'd189},'{"frac34",16'd190},'{"iquest",16'd191},
    '{"Agrave",16'd192},'{"Aacute",16'd193},'{"Acirc",16'd194},'{"Atilde",16'd195},
    '{"Auml",16'd196},'{"Aring",16'd197},'{"AElig",16'd198},'{"Ccedil",16'd199},
    '{"Egrave",16'd200},'{"Eacute",16'd201},'{"Ecirc",16'd202},'{"Euml",16'd203},
    '{"Igrave",16'd204},'{"Iacute",16'd205},'{"Icirc",16'd206},'{"Iuml",16'd207},
    '{"ETH",16'd208},'{"Ntilde",16'd209},'{"Ograve",16'd210},'{"Oacute",16'd211},
    '{"Ocirc",16'd212},'{"Otilde",16'd213},'{"Ouml",16'd214},'{"times",16'd215},
    '{"Oslash",16'd216},'{"Ugrave",16'd217},'{"Uacute",16'd218},'{"Ucirc",16'd219},
    '{"Uuml",16'd220},'{"Yacute",16'd221},'{"THORN",16'd222},'{"szlig",16'd223},
    '{"agrave",16'd224},'{"aacute",16'd225},'{"acirc",16'd226},'{"atilde",16'd227},
    '{"auml",16'd228},'{"aring",16'd229},'{"aelig",16'd230},'{"ccedil",16'd231},
    '{"egrave",16'd232},'{"eacute",16'd233},'{"ecirc",16'd234},'{"euml",16'd235},
    '{"igrave",16'd236},'{"iacute",16'd237},'{"icirc",16'd238},'{"iuml",16'd239},
    '{"eth",16'd240},'{"ntilde",16'd241},'{"ograve",16'd242},'{"oacute",16'd243},
    '{"ocirc",16'd244},'{"otilde",16'd245},'{"ouml",16'd246},'{"divide",16'd247},
    '{"oslash",16'd248},'{"ugrave",16'd249},'{"uacute",16'd250},'{"ucirc",16'd251},
    '{"uuml",16'd252},'{"yacute",16'd253},'{"thorn",16'd254},'{"yuml",16'd255},
    '{"fnof",16'd402},'{"Alpha",16'd913},'{"Beta",16'd914},'{"Gamma",16'd915},
    '{"Delta",16'd916},'{"Epsilon",16'd917},'{"Zeta",16'd918},'{"Eta",16'd919},
    '{"Theta",16'd920},'{"Iota",16'd921},'{"Kappa",16'd922},'{"Lambda",16'd923},
    '{"Mu",16'd924},'{"Nu",16'd925},'{"Xi",16'd926},'{"Omicron",16'd927},
    '{"Pi",16'd928},'{"Rho",16'd929},'{"Sigma",16'd931},'{"Tau",16'd932},
    '{"Upsilon",16'd933},'{"Phi",16'd934},'{"Chi",16'd935},'{"Psi",16'd936},
    '{"Omega",16'd937},'{"alpha",16'd945},'{"beta",16'd946},'{"gamma",16'd947},
    '{"delta",16'd948},'{"epsilon",16'd949},'{"zeta",16'd950},'{"eta",16'd951},
    '{"theta",16'd952},'{"iota",16'd953},'{"kappa",16'd954},'{"lambda",16'd955},
    '{"mu",16'd956},'{"nu",16'd957},'{"xi",16'd958},'{"omicron",16'd959},
    '{"pi",16'd960},'{"rho",16'd961},'{"sigmaf",16'd962},'{"sigma",16'd963},
    '{"tau",16'd964},'{"upsilon",16'd965},'{"phi",16'd966},'{"chi",16'd967},
    '{"psi",16'd968},'{"omega",16'd969},'{"thetasym",16'd977},'{"upsih",16'd978},
    '{"piv",16'd982},'{"bull",16'd8226},'{"hellip",16'd8230},'{"prime",16'd8242},
    '{"Prime",16'd8243},'{"oline",16'd8254},'{"frasl",16'd8260},'{"weierp",16'd8472},
    '{"image",16'd8465},'{"real",16'd8476},'{"trade",16'd8482},'{"alefsym",16'd8501},
    '{"larr",16'd8592},'{"uarr",16'd8593},'{"rarr",16'd8594},'{"darr",16'd8595},
    '{"harr",16'd8596},'{"crarr",16'd8629},'{"lArr",16'd8656},'{"uArr",16'd8657},
    '{"rArr",16'd8658},'{"dArr",16'd8659},'{"hArr",16'd8660},'{"forall",16'd8704},
    '{"part",16'd8706},'{"exist",16'd8707},'{"empty",16'd8709},'{"nabla",16'd8711},
    '{"isin",16'd8712},'{"notin",16'd8713},'{"ni",16'd8715},'{"prod",16'd8719},
    '{"sum",16'd8721},'{"minus",16'd8722},'{"lowast",16'd8727},'{"radic",16'd8730},
    '{"prop",16'd8733},'{"infin",16'd8734},'{"ang",16'd8736},'{"and",16'd8743},
    '{"or",16'd8744},'{"cap",16'd8745},'{"cup",16'd8746},'{"int",16'd8747},
    '{"there4",16'd8756},'{"sim",16'd8764},'{"cong",16'd8773},'{"asymp",16'd8776},
    '{"ne",16'd8800},'{"equiv",16'd8801},'{"le",16'd8804},'{"ge",16'd8805},
    '{"sub",16'd8834},'{"sup",16'd8835},'{"nsub",16'd8836},'{"sube",16'd8838},
    '{"supe",16'd8839},'{"oplus",16'd8853},'{"otimes",16'd8855},'{"perp",16'd8869},
    '{"sdot",16'd8901},'{"lceil",16'd8968},'{"rceil",16'd8969},'{"lfloor",16'd8970},
    '{"rfloor",16'd8971},'{"lang",16'd9001},'{"rang",16'd9002},'{"loz",16'd9674},
    '{"spades",16'd9824},'{"clubs",16'd9827},'{"hearts",16'd9829},'{"diams",16'd9830},
    '{"quot",16'd34},'{"amp",16'd38},'{"lt",16'd60},'{"gt",16'd62},
    '{"OElig",16'd338},'{"oelig",16'd339},'{"Scaron",16'd352},'{"scaron",16'd353},
    '{"Yuml",16'd376},'{"circ",16'd710},'{"tilde",16'd732},'{"ensp",16'd8194},
    '{"emsp",16'd8195},'{"thinsp",16'd8201},'{"zwnj",16'd8204},'{"zwj",16'd8205},
    '{"lrm",16'd8206},'{"rlm",16'd8207},'{"ndash",16'd8211},'{"mdash",16'd8212},
    '{"lsquo",16'd8216},'{"rsquo",16'd8217},'{"sbquo",16'd8218},'{"ldquo",16'd8220},
    '{"rdquo",16'd8221},'{"bdquo",16'd8222},'{"dagger",16'd8224},'{"Dagger",16'd8225},
    '{"permil",16'd8240},'{"lsaquo",16'd8249},'{"rsaquo",16'd8250},'{"euro",16'd8364}
  };

endpackage
`default_nettype wire

// File: rtl/core/html_entity_decoder.sv
// HTML entity decoder: 16-bit code units in, decoded units out, one item at a time.
// After acceptance the controller emits the step's units, one output beat per cycle
// while the sink is ready, and passes S_DONE before it takes the next unit. A named
// reference is looked up by walking the 252-entry name table one entry a cycle, which
// delays the result of a terminator that closes a name capture. Numeric references are
// accumulated while captured and add no lookup time. The output register holds a
// finished beat while the sink stalls.
`default_nettype none
module html_entity_decoder #(
  parameter int CAPTURE_DEPTH = hed_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hed_pkg::hed_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hed_pkg::hed_out_t out_data
);
  import hed_pkg::*;

  hed_cmd_t  cmd;
  hed_stat_t stat;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  hed_datapath #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/hed_datapath.sv
`default_nettype none
module hed_datapath #(
  parameter int CAPTURE_DEPTH = hed_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hed_pkg::hed_in_t  in_data,
  input  hed_pkg::hed_cmd_t cmd,
  output hed_pkg::hed_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output hed_pkg::hed_out_t out_data
);
  import hed_pkg::*;

  localparam int IW = $clog2(CAPTURE_DEPTH);
  localparam int CW = $clog2(CAPTURE_DEPTH + 1);

  logic [15:0]        cap_buf [CAPTURE_DEPTH];
  logic [CW-1:0]      count;
  logic [IW-1:0]      idx;
  logic               capturing;
  logic [15:0]        ch_r;
  logic               last_r;
  logic [15:0]        val_r;
  logic [15:0]        acc;
  logic               hash, hex, bad, ndig;
  logic [63:0]        cap_word;
  logic               name_ok;
  logic [NAME_IW-1:0] scan_idx;

  logic [15:0] ch;
  logic [3:0]  dig;
  logic        dig_ok;
  logic [15:0] acc_next;
  logic [15:0] emit_char;
  logic        hit;
  name_ent_t   ent;

  assign ch  = in_data.char_in;
  assign ent = NAME_ROM[scan_idx];
  assign hit = name_ok && (cap_word == ent.label) && (count == CW'(name_len(ent.label)));

  always_comb begin
    dig    = ch[3:0];
    dig_ok = 1'b0;
    if (ch inside {[16'h0030:16'h0039]}) begin
      dig_ok = 1'b1;
    end else if (hex && (ch inside {[16'h0061:16'h0066], [16'h0041:16'h0046]})) begin
      dig    = ch[3:0] + 4'd9;
      dig_ok = 1'b1;
    end
    if (hex) begin
      acc_next = {acc[11:0], dig};
    end else begin
      acc_next = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {12'h000, dig};
    end
  end

  always_comb begin
    stat.in_cap   = capturing;
    stat.in_amp   = (ch == CH_AMP);
    stat.in_semi  = (ch == CH_SEMI);
    stat.in_term  = (ch == CH_SEMI) || (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
    stat.in_last  = in_data.last_in;
    stat.full     = (count == CW'(CAPTURE_DEPTH));
    stat.cnt_zero = (count == '0);
    stat.hash     = hash;
    stat.num_ok   = hash && !bad && ndig;
    stat.scan_hit = hit;
    stat.scan_end = (scan_idx == NAME_IW'(NAME_COUNT - 1)) || !name_ok;
    stat.idx_end  = ((CW'(idx) + CW'(1)) == count);
    stat.out_free = !out_valid || out_ready;
    stat.last_r   = last_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) cap_buf[count[IW-1:0]] <= ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing <= 1'b0;
      count     <= '0;
      hash      <= 1'b0;
      hex       <= 1'b0;
      bad       <= 1'b0;
      ndig      <= 1'b0;
      acc       <= '0;
      cap_word  <= '0;
      name_ok   <= 1'b1;
    end else begin
      if (cmd.accept) capturing <= cmd.cap_val;
      if (cmd.cnt_clr) begin
        count    <= '0;
        hash     <= 1'b0;
        hex      <= 1'b0;
        bad      <= 1'b0;
        ndig     <= 1'b0;
        acc      <= '0;
        cap_word <= '0;
        name_ok  <= 1'b1;
      end else if (cmd.append) begin
        count    <= count + CW'(1);
        cap_word <= {cap_word[55:0], ch[7:0]};
        if ((ch[15:8] != 8'h00) || (count >= CW'(8))) name_ok <= 1'b0;
        if (count == '0) begin
          hash <= (ch == CH_HASH);
        end else if (hash) begin
          if ((count == CW'(1)) && (ch == CH_X)) begin
            hex <= 1'b1;
          end else if (dig_ok) begin
            acc  <= acc_next;
            ndig <= 1'b1;
          end else begin
            bad <= 1'b1;
          end
        end
      end
    end
  end

  // latch the beat, then walk the name table or the buffer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r     <= ch;
      last_r   <= in_data.last_in;
      val_r    <= acc;
      scan_idx <= '0;
      idx      <= '0;
    end else begin
      if (cmd.scan) begin
        if (hit) val_r <= ent.point;
        else scan_idx <= scan_idx + NAME_IW'(1);
      end
      if (cmd.idx_inc) idx <= idx + IW'(1);
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_VAL: emit_char = val_r;
      SEL_AMP: emit_char = CH_AMP;
      SEL_BUF: emit_char = cap_buf[idx];
      SEL_CH:  emit_char = ch_r;
      default: emit_char = ch_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.char_out <= emit_char;
      out_data.last_out <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hed_ctrl.sv
`default_nettype none
module hed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output hed_pkg::hed_cmd_t  cmd,
  input  hed_pkg::hed_stat_t stat
);
  import hed_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_VAL     = 3'd2;
  localparam logic [2:0] S_RAW_AMP = 3'd3;
  localparam logic [2:0] S_BUF     = 3'd4;
  localparam logic [2:0] S_CH      = 3'd5;
  localparam logic [2:0] S_AMP     = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state, state_next;
  logic p_v, p_raw, p_ch, p_amp, clr_end;
  logic p_v_next, p_raw_next, p_ch_next, p_amp_next, clr_end_next;

  function automatic logic [2:0] first_state(input logic v, input logic raw,
                                             input logic c, input logic a);
    if (v) return S_VAL;
    else if (raw) return S_RAW_AMP;
    else if (c) return S_CH;
    else if (a) return S_AMP;
    else return S_DONE;
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    p_v_next     = p_v;
    p_raw_next   = p_raw;
    p_ch_next    = p_ch;
    p_amp_next   = p_amp;
    clr_end_next = clr_end;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept   = 1'b1;
          p_v_next     = 1'b0;
          p_raw_next   = 1'b0;
          p_ch_next    = 1'b0;
          p_amp_next   = 1'b0;
          clr_end_next = 1'b1;
          if (!stat.in_cap) begin
            if (stat.in_amp) begin
              cmd.cap_val = !stat.in_last;
              cmd.cnt_clr = 1'b1;
              p_amp_next  = stat.in_last;
            end else begin
              p_ch_next = 1'b1;
            end
          end else if (stat.in_term) begin
            if (!stat.cnt_zero && stat.hash) begin
              if (stat.num_ok) begin
                p_v_next  = 1'b1;
                p_ch_next = !stat.in_semi;
              end else begin
                p_raw_next = 1'b1;
                p_ch_next  = 1'b1;
              end
            end else if (stat.cnt_zero) begin
              p_raw_next = 1'b1;
              p_ch_next  = 1'b1;
            end
          end else if (stat.in_amp) begin
            cmd.cap_val = !stat.in_last;
            p_raw_next  = 1'b1;
            p_amp_next  = stat.in_last;
          end else if (!stat.full) begin
            cmd.append   = 1'b1;
            cmd.cap_val  = !stat.in_last;
            p_raw_next   = stat.in_last;
            clr_end_next = stat.in_last;
          end else begin
            p_raw_next = 1'b1;
            p_ch_next  = 1'b1;
          end
          if (stat.in_cap && stat.in_term && !stat.cnt_zero && !stat.hash) begin
            state_next = S_SCAN;
          end else begin
            state_next = first_state(p_v_next, p_raw_next, p_ch_next, p_amp_next);
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit) begin
          p_v_next   = 1'b1;
          state_next = S_VAL;
        end else if (stat.scan_end) begin
          p_raw_next = 1'b1;
          p_ch_next  = 1'b1;
          state_next = S_RAW_AMP;
        end
      end
      S_VAL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_VAL;
          p_v_next   = 1'b0;
          state_next = first_state(1'b0, p_raw, p_ch, p_amp);
        end
      end
      S_RAW_AMP: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_AMP;
          if (!stat.cnt_zero) begin
            state_next = S_BUF;
          end else begin
            p_raw_next = 1'b0;
            state_next = first_state(1'b0, 1'b0, p_ch, p_amp);
          end
        end
      end
      S_BUF: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_BUF;
          cmd.idx_inc = 1'b1;
          if (stat.idx_end) begin
            p_raw_next = 1'b0;
            state_next = first_state(1'b0, 1'b0, p_ch, p_amp);
          end
        end
      end
      S_CH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_CH;
          p_ch_next  = 1'b0;
          state_next = first_state(1'b0, 1'b0, 1'b0, p_amp);
        end
      end
      S_AMP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_AMP;
          p_amp_next = 1'b0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.cnt_clr = clr_end;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // mark the final beat of a step that closes the text
    cmd.emit_last = cmd.emit && stat.last_r && (state_next == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_v     <= 1'b0;
      p_raw   <= 1'b0;
      p_ch    <= 1'b0;
      p_amp   <= 1'b0;
      clr_end <= 1'b0;
    end else begin
      state   <= state_next;
      p_v     <= p_v_next;
      p_raw   <= p_raw_next;
      p_ch    <= p_ch_next;
      p_amp   <= p_amp_next;
      clr_end <= clr_end_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hed_checker.sv
`default_nettype none
`include "html_entity_decoder_defines.svh"
module hed_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hed_pkg::hed_out_t out_data
);
  import hed_pkg::*;

  `HED_ASSERT_NEXT(a_rst_out_empty, rst, !out_valid, "output beat present after reset")
  `HED_ASSERT_NEXT_RUN(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted two beats back to back")
  `HED_ASSERT_NEXT_RUN(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output beat changed")

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: verif/tb_html_entity_decoder.sv
`default_nettype none
module tb_html_entity_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import hed_pkg::*;

  localparam int DEPTH = CAPTURE_DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;

  // Expected output beats in arrival order, plus the decoder state that produces them.
  class entity_scoreboard;
    hed_out_t pending_beats[$];
    bit open_capture;
    logic [15:0] captured[DEPTH];
    int captured_len;
    int mismatches;

    function void clear();
      pending_beats.delete();
      open_capture = 0;
      captured_len = 0;
      mismatches = 0;
    endfunction

    function void emit(logic [15:0] ch);
      hed_out_t b;
      b.char_out = ch;
      b.last_out = 1'b0;
      pending_beats.push_back(b);
    endfunction

    function void emit_raw();
      emit(CH_AMP);
      for (int i = 0; i < captured_len; i++) emit(captured[i]);
    endfunction

    function bit is_term(logic [15:0] ch);
      return ch == CH_SEMI || ch == CH_SPACE || ch == CH_TAB || ch == CH_LF;
    endfunction

    function bit numeric_value(output logic [15:0] val);
      int first;
      int radix;
      int digit;
      logic [15:0] c;
      val = '0;
      if (captured_len < 1 || captured[0] != CH_HASH) return 0;
      if (captured_len >= 2 && captured[1] == CH_X) begin
        first = 2;
        radix = 16;
      end else begin
        first = 1;
        radix = 10;
      end
      if (first >= captured_len) return 0;
      for (int i = first; i < captured_len; i++) begin
        c = captured[i];
        if (c >= "0" && c <= "9") digit = c - "0";
        else if (radix == 16 && c >= "a" && c <= "f") digit = c - "a" + 10;
        else if (radix == 16 && c >= "A" && c <= "F") digit = c - "A" + 10;
        else return 0;
        val = val * radix + digit;
      end
      return 1;
    endfunction

    function bit name_value(output logic [15:0] val);
      int len;
      bit same;
      val = '0;
      for (int e = 0; e < NAME_COUNT; e++) begin
        len = 0;
        for (int k = 0; k < 8; k++) if (NAME_ROM[e].label[k*8 +: 8] != 8'h00) len++;
        if (len != captured_len) continue;
        same = 1;
        // label is packed right-aligned: first char sits in the highest used byte
        for (int k = 0; k < len; k++)
          if (captured[k] != {8'h00, NAME_ROM[e].label[(len-1-k)*8 +: 8]}) same = 0;
        if (same) begin
          val = NAME_ROM[e].point;
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_input(hed_in_t item);
      logic [15:0] ch;
      logic [15:0] val;
      int start_size;
      ch = item.char_in;
      start_size = pending_beats.size();
      if (!open_capture) begin
        if (ch == CH_AMP) begin
          open_capture = 1;
          captured_len = 0;
        end else emit(ch);
      end else if (is_term(ch)) begin
        open_capture = 0;
        if (captured_len > 0 && captured[0] == CH_HASH) begin
          if (numeric_value(val)) begin
            emit(val);
            if (ch != CH_SEMI) emit(ch);
          end else begin
            emit_raw();
            emit(ch);
          end
        end else if (captured_len > 0 && name_value(val)) emit(val);
        else begin
          emit_raw();
          emit(ch);
        end
        captured_len = 0;
      end else if (ch == CH_AMP) begin
        emit_raw();
        captured_len = 0;
      end else if (captured_len < DEPTH) begin
        captured[captured_len] = ch;
        captured_len++;
      end else begin
        emit_raw();
        emit(ch);
        open_capture = 0;
        captured_len = 0;
      end
      if (item.last_in) begin
        if (open_capture) emit_raw();
        open_capture = 0;
        captured_len = 0;
        if (pending_beats.size() > start_size)
          pending_beats[pending_beats.size()-1].last_out = 1'b1;
      end
    endfunction

    function void check_beat(hed_out_t got);
      hed_out_t want;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat char=%h last=%b", got.char_out, got.last_out);
        return;
      end
      want = pending_beats.pop_front();
      if (got.char_out !== want.char_out || got.last_out !== want.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat mismatch: want char=%h last=%b got char=%h last=%b",
                   want.char_out, want.last_out, got.char_out, got.last_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  hed_in_t in_data;
  logic out_valid;
  logic out_ready;
  hed_out_t out_data;

  int send_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;
  entity_scoreboard board;

  html_entity_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sink side: random stall, check every accepted beat
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) board.check_beat(out_data);
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog: count cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays up across back-to-back beats; drop it only while idling
  task automatic send_char(logic [15:0] ch, bit last = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: ch, last_in: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(in_data);
  endtask

  task automatic send_text(string s, bit last = 0);
    for (int i = 0; i < s.len(); i++)
      send_char({8'h00, s[i]}, last && i == s.len() - 1);
  endtask

  function automatic logic [15:0] random_term();
    case ($urandom_range(3))
      0: return CH_SEMI;
      1: return CH_SPACE;
      2: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [15:0] random_unit();
    case ($urandom_range(5))
      0: return $urandom_range(16'hFFFF);
      1: return "0" + $urandom_range(9);
      2: return "a" + $urandom_range(25);
      3: return "A" + $urandom_range(25);
      4: return random_term();
      default: return CH_AMP;
    endcase
  endfunction

  // one reference of random shape: name, decimal, hex, broken, or long around the capture depth
  task automatic send_reference();
    int e;
    int len;
    send_char(CH_AMP);
    case ($urandom_range(5))
      0, 1: begin
        e = $urandom_range(NAME_COUNT - 1);
        len = 0;
        for (int k = 0; k < 8; k++) if (NAME_ROM[e].label[k*8 +: 8] != 8'h00) len++;
        for (int k = len - 1; k >= 0; k--) send_char({8'h00, NAME_ROM[e].label[k*8 +: 8]});
      end
      2: begin
        send_char(CH_HASH);
        repeat ($urandom_range(1, 7)) send_char("0" + $urandom_range(9));
      end
      3: begin
        send_char(CH_HASH);
        send_char(CH_X);
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(2))
            0: send_char("0" + $urandom_range(9));
            1: send_char("a" + $urandom_range(5));
            default: send_char("A" + $urandom_range(5));
          endcase
        end
      end
      4: repeat ($urandom_range(0, 5)) send_char(random_unit());
      default: repeat ($urandom_range(DEPTH - 1, DEPTH + 2)) send_char("a" + $urandom_range(25));
    endcase
    send_char(random_term(), $urandom_range(9) == 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int refs);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (refs) begin
      if ($urandom_range(3) == 0) send_char(random_unit(), $urandom_range(15) == 0);
      else begin
        repeat ($urandom_range(0, 2)) send_char("a" + $urandom_range(25));
        send_reference();
      end
    end
  endtask

  initial begin
    board = new();
    board.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, names, numeric forms and the repair cases
    send_char(16'h0000);
    send_char(16'hFFFF);
    send_text("&nbsp;&euro ");
    send_text("&#65;&#x41\t&#x4a;&#99999;");
    send_text("&#;&#x;&#1a;&#X41;&; &bogus\n");
    send_text("&lt&amp;gt;");
    send_text("&abcdefghijklmnopq;");
    send_text("&#12", 1);
    send_text("&", 1);
    send_char(16'h5555, 1);

    run_phase(0, 0, 5);
    run_phase(81, 0, 4);
    run_phase(0, 81, 4);
    run_phase(29, 29, 4);
    send_char(CH_SEMI, 1);
    in_valid <= 1'b0;

    while (board.pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.pending_beats.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/hed_pkg.sv
rtl/core/hed_datapath.sv
rtl/core/hed_ctrl.sv
rtl/core/html_entity_decoder.sv
rtl/core/hed_checker.sv
verif/tb_html_entity_decoder.sv
